>>> rtl/iprf_pkg.sv
// iprf_pkg: shared types and constants for integer_pair_ratio_float.
// No dependencies.
`timescale 1ns / 1ps
package iprf_pkg;
  localparam int MW = 53;
  localparam int QW = 55;
  typedef enum logic [1:0] {
    REG_LOW  = 2'd0,
    REG_HIGH = 2'd1,
    REG_HALF = 2'd2
  } reg_idx_t;
  typedef struct packed {
    logic        special;
    logic [63:0] sbits;
    logic [10:0] exp;
    logic [MW-1:0] div;
    logic [MW:0]   rem;
    logic [QW-1:0] quo;
  } cell_t;
endpackage

>>> rtl/iprf_cvt.sv
// iprf_cvt: unsigned 64-bit to 53-bit significand with RNE, returns exponent p.
// Depends on iprf_pkg.
`timescale 1ns / 1ps
module iprf_cvt (
  input  logic [63:0] v,
  output logic [iprf_pkg::MW-1:0] mant,
  output logic [6:0]  p
);
  logic [5:0]  lz;
  logic [63:0] nv;
  logic [53:0] m;
  logic        g, st;
  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 64; i++) if (v[i]) lz = 6'(63 - i);
    nv = v << lz;
    g  = nv[10];
    st = |nv[9:0];
    m  = {1'b0, nv[63:11]} + 54'(g && (st || nv[11]));
    if (m[53]) begin
      mant = m[53:1];
      p    = 7'(64 - lz);
    end else begin
      mant = m[52:0];
      p    = 7'(63 - lz);
    end
  end
endmodule

>>> rtl/iprf_cell.sv
// iprf_cell: one restoring-division step and pipeline register.
// Depends on iprf_pkg.
`timescale 1ns / 1ps
module iprf_cell (
  input  logic clk,
  input  logic en,
  input  iprf_pkg::cell_t din,
  output iprf_pkg::cell_t dout
);
  iprf_pkg::cell_t c_nxt;
  logic [iprf_pkg::MW:0] d;
  always_comb begin
    c_nxt = din;
    d = din.rem - {1'b0, din.div};
    if (!d[iprf_pkg::MW]) begin
      c_nxt.rem = {d[iprf_pkg::MW-1:0], 1'b0};
      c_nxt.quo = {din.quo[iprf_pkg::QW-2:0], 1'b1};
    end else begin
      c_nxt.rem = {din.rem[iprf_pkg::MW-1:0], 1'b0};
      c_nxt.quo = {din.quo[iprf_pkg::QW-2:0], 1'b0};
    end
  end
  always_ff @(posedge clk) begin
    if (en) dout <= c_nxt;
  end
endmodule

>>> rtl/integer_pair_ratio_float.sv
// integer_pair_ratio_float: top level, front conversion, divider cell row, rounding.
// Depends on iprf_pkg, iprf_cvt, iprf_cell.
// channel | dir | handshake       | word
// in_     | in  | in_valid/stall  | first_draw, second_draw
// out_    | out | out_valid/stall | value_bits
// cfg_    | in  | cfg_valid/ready | index, data
// One word per cycle while out_stall does not freeze the pipe; out_valid follows the accepting edge
// through the front register, 55 divider cells and the round register.
// The row of cells advances as one pipe; out_stall with a valid output word freezes it.
// rst_n synchronous low clears valid bits and the configuration registers.
`timescale 1ns / 1ps
module integer_pair_ratio_float (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_first_draw,
  input  logic [63:0] in_second_draw,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_value_bits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  localparam int NC = iprf_pkg::QW;
  localparam int MW = iprf_pkg::MW;
  logic [63:0] low_r, high_r, half_r;
  logic [NC+1:0] vld_r;
  logic adv;
  iprf_pkg::cell_t pipe [NC+1];
  iprf_pkg::cell_t front_nxt;
  logic [MW-1:0] ma, mb;
  logic [6:0] pa, pb;
  logic [63:0] lo, hi;
  logic [63:0] out_r, res_nxt;
  assign adv = !out_stall || !vld_r[NC+1];
  assign in_stall = !adv;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[NC+1];
  assign out_value_bits = out_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r <= '0; high_r <= '0; half_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        iprf_pkg::REG_LOW:  low_r  <= cfg_data;
        iprf_pkg::REG_HIGH: high_r <= cfg_data;
        iprf_pkg::REG_HALF: half_r <= cfg_data;
        default: ;
      endcase
    end
  end
  assign lo = (in_first_draw < in_second_draw) ? in_first_draw : in_second_draw;
  assign hi = (in_first_draw < in_second_draw) ? in_second_draw : in_first_draw;
  iprf_cvt u_cva (.v(lo), .mant(ma), .p(pa));
  iprf_cvt u_cvb (.v(hi), .mant(mb), .p(pb));
  always_comb begin
    front_nxt = '0;
    if (in_first_draw == in_second_draw) begin
      front_nxt.special = 1'b1;
      front_nxt.sbits = (in_first_draw < half_r) ? low_r : high_r;
    end else if (in_first_draw == 64'd0) begin
      front_nxt.special = 1'b1;
      front_nxt.sbits = low_r;
    end else if (in_second_draw == 64'd0) begin
      front_nxt.special = 1'b1;
      front_nxt.sbits = high_r;
    end
    front_nxt.exp = 11'(11'd1023 + {4'd0, pa} - {4'd0, pb});
    front_nxt.div = mb;
    front_nxt.rem = {1'b0, ma};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NC:0], in_valid};
  end
  always_ff @(posedge clk) begin
    if (adv) pipe[0] <= front_nxt;
  end
  for (genvar i = 0; i < NC; i++) begin : g_cell
    iprf_cell u_cell (.clk(clk), .en(adv), .din(pipe[i]), .dout(pipe[i+1]));
  end
  // quotient in [0.5,2): 55 bits = 1 int + 54 frac (or leading 0)
  logic [iprf_pkg::QW-1:0] q;
  logic [52:0] m;
  logic [53:0] mr;
  logic [10:0] e;
  logic gb, sb;
  always_comb begin
    q = pipe[NC].quo;
    sb = |pipe[NC].rem;
    if (q[NC-1]) begin
      m = q[54:2]; gb = q[1]; sb = sb || q[0]; e = pipe[NC].exp;
    end else begin
      m = q[53:1]; gb = q[0]; e = pipe[NC].exp - 11'd1;
    end
    mr = {1'b0, m} + 54'(gb && (sb || m[0]));
    if (mr[53]) e = e + 11'd1;
    res_nxt = pipe[NC].special ? pipe[NC].sbits
            : {1'b0, e, mr[53] ? 52'd0 : mr[51:0]};
  end
  always_ff @(posedge clk) begin
    if (adv) out_r <= res_nxt;
  end
  ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_bits))
    else $error("output word changed under stall");
  ap_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("stall without blocked output");
  ap_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipe moved while frozen");
endmodule

>>> dv/integer_pair_ratio_float_tb.sv
// integer_pair_ratio_float_tb: self-checking bench for the integer pair ratio block.
// Drives draw pairs and register writes, predicts each binary64 quotient, checks in order.
// Depends on iprf_pkg and integer_pair_ratio_float.
`timescale 1ns / 1ps
module integer_pair_ratio_float_tb;

  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int WDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES = 70;
  localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_first_draw = '0;
  logic [63:0] in_second_draw = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_value_bits;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  logic [63:0] low_edge_q, high_edge_q, half_range_q;
  logic [63:0] ratio_q[$];
  int          errors = 0;
  int          wdog = 0;
  bit          quiet = 1'b0;

  integer_pair_ratio_float u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] u64_to_bits(logic [63:0] v);
    int          p;
    int          sh;
    logic [63:0] mant, rem, half;
    if (v == 0) return '0;
    p = 63;
    while (!v[p]) p--;
    if (p <= 52) begin
      mant = v << (52 - p);
    end else begin
      sh = p - 52;
      rem = v & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      mant = v >> sh;
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant == (64'd1 << 53)) begin
        mant = mant >> 1;
        p++;
      end
    end
    return {1'b0, 11'(1023 + p), mant[51:0]};
  endfunction

  function automatic logic [63:0] pair_ratio(logic [63:0] a, logic [63:0] b);
    logic [63:0] lo, hi;
    real q;
    if (a == b) return (a < half_range_q) ? low_edge_q : high_edge_q;
    if (a == 0) return low_edge_q;
    if (b == 0) return high_edge_q;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    q = $bitstoreal(u64_to_bits(lo)) / $bitstoreal(u64_to_bits(hi));
    return $realtobits(q);
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      low_edge_q <= '0;
      high_edge_q <= '0;
      half_range_q <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          iprf_pkg::REG_LOW:  low_edge_q <= cfg_data;
          iprf_pkg::REG_HIGH: high_edge_q <= cfg_data;
          iprf_pkg::REG_HALF: half_range_q <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) ratio_q.push_back(pair_ratio(in_first_draw, in_second_draw));
      if (out_valid && !out_stall) begin
        if (ratio_q.size() == 0) report("unexpected word", out_value_bits, '0);
        else if (out_value_bits !== ratio_q[0]) report("value_bits", out_value_bits, ratio_q[0]);
        if (ratio_q.size() != 0) void'(ratio_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("watchdog expired at %0t", $realtime);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 15);

  task automatic send_pair(logic [63:0] a, logic [63:0] b);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_first_draw = a;
    in_second_draw = b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    @(negedge clk);
    in_valid = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (ratio_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_draw();
    case ($urandom_range(9))
      0: return 64'($urandom_range(15));
      1: return ALL1 - $urandom_range(15);
      2: return rand64() >> $urandom_range(63);
      default: return rand64();
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_pair(64'd0, 64'd0);
    send_pair(64'd5, 64'd5);
    send_pair(64'd0, 64'd9);
    send_pair(64'd9, 64'd0);
    send_pair(64'd3, 64'd7);
    drain();
  endtask

  task automatic test_edges_directed();
    write_reg(iprf_pkg::REG_LOW, 64'h3CA0_0000_0000_0000);
    write_reg(iprf_pkg::REG_HIGH, 64'h3FEF_FFFF_FFFF_FFFF);
    write_reg(iprf_pkg::REG_HALF, 64'h8000_0000_0000_0000);
    write_reg(REG_NONE, ALL1);
    send_pair(64'd0, ALL1);
    send_pair(ALL1, 64'd0);
    send_pair(64'd1, ALL1);
    send_pair(ALL1 - 1, ALL1);
    send_pair(ALL1, 64'd1);
    send_pair(64'd1, 64'd2);
    send_pair(64'd3, 64'd1);
    send_pair(64'h0020_0000_0000_0001, 64'h0020_0000_0000_0003);
    send_pair(64'h0040_0000_0000_0002, 64'h0040_0000_0000_0006);
    send_pair(64'hFFFF_FFFF_FFFF_FC00, ALL1);
    send_pair(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    send_pair(64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
    send_pair(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_pair(ALL1, ALL1);
    send_pair(64'h0010_0000_0000_0000, 64'h001F_FFFF_FFFF_FFFF);
    drain();
  endtask

  task automatic test_ties();
    write_reg(iprf_pkg::REG_HALF, 64'd0);
    send_pair(64'd0, 64'd0);
    send_pair(ALL1, ALL1);
    drain();
    write_reg(iprf_pkg::REG_HALF, ALL1);
    write_reg(iprf_pkg::REG_LOW, ALL1);
    write_reg(iprf_pkg::REG_HIGH, 64'd0);
    send_pair(ALL1 - 1, ALL1 - 1);
    send_pair(ALL1, ALL1);
    send_pair(64'd0, 64'd0);
    drain();
  endtask

  task automatic test_random(int n, bit calm);
    logic [63:0] a, b;
    write_reg(iprf_pkg::REG_LOW, rand64());
    write_reg(iprf_pkg::REG_HIGH, rand64());
    write_reg(iprf_pkg::REG_HALF, rand64());
    quiet = calm;
    repeat (n) begin
      a = rand_draw();
      b = rand_draw();
      case ($urandom_range(19))
        0, 1: b = a;
        2: a = '0;
        3: b = '0;
        default: ;
      endcase
      send_pair(a, b);
    end
    drain();
    quiet = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_edges_directed();
    test_ties();
    test_random(230, 1'b0);
    test_random(230, 1'b1);
    test_random(230, 1'b0);
    test_random(230, 1'b0);
    test_random(230, 1'b0);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
